@@ sv/quantized_fir_filter_top_macros.svh @@
// Assertion macros shared by the quantized FIR filter RTL.
`ifndef QUANTIZED_FIR_FILTER_TOP_MACROS_SVH
`define QUANTIZED_FIR_FILTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define QFIR_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qfir: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define QFIR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qfir: next-cycle check failed");

`endif

@@ sv/qfir_pkg.sv @@
// Package: types, constants and register map of the quantized FIR filter.
`default_nettype none

package qfir_pkg;

	// Parameter defaults
	localparam int MAX_TAPS_DEF     = 8;
	localparam int LEVELS_DEF       = 8;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// Fixed field widths
	localparam int COEF_W      = 8;   // Q1.7 coefficient
	localparam int LVL_W       = 8;   // Q4.4 level
	localparam int THR_W       = 16;  // Q8.8 threshold
	localparam int PROD_W      = COEF_W + LVL_W;
	localparam int SUM_W       = 19;  // exact sum of up to eight products
	localparam int FULL_W      = 18;
	localparam int NARROW_W    = 8;
	localparam int NARROW_LSB  = 4;
	localparam int COEF_SLOTS  = 8;
	localparam int STORED_THR  = 7;
	localparam int CB_LEVELS   = 8;
	localparam int IDX_W       = 3;
	localparam int TAP_CNT_W   = 4;
	localparam int THR_LO_W    = 64;
	localparam int THR_HI_W    = 48;
	localparam int REG_W       = 64;

	// Configuration port
	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;
	localparam int REG_IDX_LSB = 3;
	localparam int REG_IDX_W   = ADDR_W - REG_IDX_LSB;

	localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = TAP_CNT_W'(8);

	// Queue between quantizer and filter engine
	localparam int QDEPTH = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_COEF     = REG_IDX_W'(0),
		REG_TAPS     = REG_IDX_W'(1),
		REG_THR_LO   = REG_IDX_W'(2),
		REG_THR_HI   = REG_IDX_W'(3),
		REG_CODEBOOK = REG_IDX_W'(4)
	} qfir_reg_t;

	typedef enum logic {
		BK_RUN,
		BK_TAIL
	} qfir_back_state_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic             blk_end;
	} qfir_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qfir_qstat_t;

	typedef struct packed {
		logic tail;
		logic emit;
		logic last;
	} qfir_back_stat_t;

endpackage

`default_nettype wire

@@ sv/qfir_if.sv @@
// Channel interfaces: sample input and filter result output.
`default_nettype none

interface qfir_in_if #(parameter int SAMPLE_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           block_end;

	modport source (output valid, output sample, output block_end, input ready);
	modport sink   (input valid, input sample, input block_end, output ready);
endinterface

interface qfir_out_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] full_sum;
	logic signed [7:0]  narrow_out;
	logic               final_out;

	modport source (output valid, output full_sum, output narrow_out, output final_out,
		input ready);
	modport sink   (input valid, input full_sum, input narrow_out, input final_out,
		output ready);
endinterface

`default_nettype wire

@@ sv/quantized_fir_filter_top.sv @@
// Top level: configuration registers, quantizer front end, queue and filter engine.
//
//  channel   | dir | handshake            | payload
//  ----------+-----+----------------------+-------------------------------------
//  samples   | in  | valid / ready        | sample (Q8.8), block_end
//  results   | out | valid / ready        | full_sum (Q7.11), narrow_out, final_out
//  config    | in  | APB psel/penable     | paddr, pwdata, prdata (64-bit regs)
//
//  One sample per clock in steady state, while results are taken and no tail
//  flush runs. A sample with block_end set is followed by a tail flush of the
//  filter engine (one zero-level output for each tap beyond the first), while the
//  queue keeps taking samples until it fills. Each sample is written to the queue
//  on its transfer edge, then passes the product stage and the result register.
//  Reset clears the delay line, queue and pipeline valids, and loads the
//  register defaults (tap_count 8, the others zero).
//  results.ready low holds the result register; the product stage and the
//  queue absorb the stall before samples.ready drops.
`default_nettype none

`include "quantized_fir_filter_top_macros.svh"

module quantized_fir_filter_top
	import qfir_pkg::*;
#(
	parameter int MAX_TAPS     = MAX_TAPS_DEF,
	parameter int LEVELS       = LEVELS_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output      logic [DATA_W-1:0] prdata,
	output      logic              pready,
	qfir_in_if.sink                samples,
	qfir_out_if.source             results
);

	logic [REG_W-1:0]     coef_q;
	logic [TAP_CNT_W-1:0] taps_q;
	logic [THR_LO_W-1:0]  thr_lo_q;
	logic [THR_HI_W-1:0]  thr_hi_q;
	logic [REG_W-1:0]     cb_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	qfir_qstat_t     qstat;
	qfir_entry_t     q_in, q_head;
	logic            q_push, q_pop;
	qfir_back_stat_t bstat;

	// Configuration port: zero wait states, register i at byte 8*i.
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:REG_IDX_LSB];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= '0;
			taps_q   <= TAP_COUNT_RESET;
			thr_lo_q <= '0;
			thr_hi_q <= '0;
			cb_q     <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_COEF:     coef_q   <= pwdata;
				REG_TAPS:     taps_q   <= pwdata[TAP_CNT_W-1:0];
				REG_THR_LO:   thr_lo_q <= pwdata[THR_LO_W-1:0];
				REG_THR_HI:   thr_hi_q <= pwdata[THR_HI_W-1:0];
				REG_CODEBOOK: cb_q     <= pwdata;
				default: ;  // drop writes past the register map
			endcase
		end
	end

	// Read back the addressed register, zero past the map.
	always_comb begin
		case (reg_idx)
			REG_COEF:     prdata = coef_q;
			REG_TAPS:     prdata = DATA_W'(taps_q);
			REG_THR_LO:   prdata = DATA_W'(thr_lo_q);
			REG_THR_HI:   prdata = DATA_W'(thr_hi_q);
			REG_CODEBOOK: prdata = cb_q;
			default:      prdata = '0;
		endcase
	end

	// Quantize each sample as it transfers in.
	qfir_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.LEVELS       (LEVELS)
	) u_front (
		.thresholds_low  (thr_lo_q),
		.thresholds_high (thr_hi_q),
		.codebook        (cb_q),
		.qstat           (qstat),
		.push            (q_push),
		.push_data       (q_in),
		.samples         (samples)
	);

	// Decouple the front end from the tail flush of the engine.
	qfir_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (qstat)
	);

	// Convolve, flush tails on block end, and hold results for transfer.
	qfir_back #(
		.MAX_TAPS (MAX_TAPS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.coefficients (coef_q),
		.tap_count    (taps_q),
		.qstat        (qstat),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.stat         (bstat),
		.results      (results)
	);

	// The engine never pulls a queued level during a tail flush.
	`QFIR_ASSERT_IMPL(a_no_pop_in_tail, bstat.tail, !q_pop)
	// The queue can not read full and empty at once.
	`QFIR_ASSERT_IMPL(a_queue_sane, 1'b1, !(qstat.full && qstat.empty))
	// The last result of a block always returns the engine to normal run.
	`QFIR_ASSERT_NEXT(a_flush_ends, bstat.emit && bstat.last, !bstat.tail)
	// A pushed level is visible in the queue on the next cycle.
	`QFIR_ASSERT_NEXT(a_push_lands, q_push, !qstat.empty)

endmodule

`default_nettype wire

@@ sv/qfir_front.sv @@
// Front end: accept samples, quantize to a codebook level, push to the queue.
`default_nettype none

module qfir_front
	import qfir_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int LEVELS       = LEVELS_DEF
) (
	input  wire logic [THR_LO_W-1:0] thresholds_low,
	input  wire logic [THR_HI_W-1:0] thresholds_high,
	input  wire logic [REG_W-1:0]    codebook,
	input  wire qfir_qstat_t         qstat,
	output      logic                push,
	output      qfir_entry_t         push_data,
	qfir_in_if.sink                  samples
);

	localparam int CW  = (SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W;
	localparam int NTH = (LEVELS - 1 < STORED_THR) ? LEVELS - 1 : STORED_THR;

	logic [THR_LO_W+THR_HI_W-1:0] thr_all;
	logic signed [CW-1:0]         s_ext;
	logic [IDX_W-1:0]             idx;

	assign thr_all = {thresholds_high, thresholds_low};
	assign s_ext   = CW'(samples.sample);

	// Count thresholds strictly below the sample; the count tops out at NTH.
	always_comb begin
		idx = '0;
		for (int i = 0; i < NTH; i++) begin
			if (CW'(signed'(thr_all[THR_W*i +: THR_W])) < s_ext) begin
				idx = idx + IDX_W'(1);
			end
		end
	end

	assign samples.ready     = !qstat.full;
	assign push              = samples.valid && !qstat.full;
	assign push_data.level   = codebook[LVL_W*idx +: LVL_W];
	assign push_data.blk_end = samples.block_end;

endmodule

`default_nettype wire

@@ sv/qfir_queue.sv @@
// Short queue of quantized levels between the front end and the filter engine.
`default_nettype none

module qfir_queue
	import qfir_pkg::*;
#(
	parameter int DEPTH = QDEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire qfir_entry_t push_data,
	input  wire logic        pop,
	output      qfir_entry_t head,
	output      qfir_qstat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	qfir_entry_t      mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CNTW'(DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

`default_nettype wire

@@ sv/qfir_back.sv @@
// Filter engine: delay line, tail flush sequencer, product stage and result register.
`default_nettype none

module qfir_back
	import qfir_pkg::*;
#(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [REG_W-1:0]     coefficients,
	input  wire logic [TAP_CNT_W-1:0] tap_count,
	input  wire qfir_qstat_t          qstat,
	input  wire qfir_entry_t          q_head,
	output      logic                 q_pop,
	output      qfir_back_stat_t      stat,
	qfir_out_if.source                results
);

	localparam int LINE_DEPTH = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
	localparam int NPROD      = (MAX_TAPS < COEF_SLOTS) ? MAX_TAPS : COEF_SLOTS;
	localparam int TW         = ($clog2(MAX_TAPS + 1) > TAP_CNT_W) ?
		$clog2(MAX_TAPS + 1) : TAP_CNT_W;

	qfir_back_state_t     state_q, state_d;
	logic [TW-1:0]        tail_q;
	logic [TW-1:0]        tc_ext, taps;
	logic                 tail_last;
	logic                 emit, last;
	logic [LVL_W-1:0]     lvl;
	logic [LVL_W-1:0]     line_q [LINE_DEPTH];
	logic [LVL_W-1:0]     line_d [LINE_DEPTH];
	logic signed [PROD_W-1:0] prod_d  [NPROD];
	logic signed [PROD_W-1:0] prod_s1 [NPROD];
	logic                 vld_s1, last_s1;
	logic                 s1_can, out_load;
	logic signed [SUM_W-1:0] sum;
	logic                 out_vld_q;
	logic [FULL_W-1:0]    full_q;
	logic [NARROW_W-1:0]  narrow_q;
	logic                 final_q;

	// Taps in use: zero acts as one, anything above MAX_TAPS as MAX_TAPS.
	always_comb begin
		tc_ext = TW'(tap_count);
		if (tc_ext == '0) begin
			taps = TW'(1);
		end else if (tc_ext > TW'(MAX_TAPS)) begin
			taps = TW'(MAX_TAPS);
		end else begin
			taps = tc_ext;
		end
	end

	assign tail_last = (tail_q == taps - TW'(1));
	assign out_load  = !out_vld_q || results.ready;
	assign s1_can    = !vld_s1 || out_load;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_RUN: begin
				if (q_pop && q_head.blk_end && taps != TW'(1)) begin
					state_d = BK_TAIL;
				end
			end
			BK_TAIL: begin
				if (emit && tail_last) begin
					state_d = BK_RUN;
				end
			end
			default: state_d = BK_RUN;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		emit  = 1'b0;
		lvl   = q_head.level;
		last  = 1'b0;
		case (state_q)
			BK_RUN: begin
				q_pop = !qstat.empty && s1_can;
				emit  = q_pop;
				last  = q_head.blk_end && (taps == TW'(1));
			end
			BK_TAIL: begin
				emit = s1_can;
				lvl  = '0;
				last = tail_last;
			end
			default: ;
		endcase
	end

	// Shift the new level in; the last result of a block clears the line.
	always_comb begin
		line_d[0] = last ? '0 : lvl;
		for (int i = 1; i < LINE_DEPTH; i++) begin
			line_d[i] = last ? '0 : line_q[i-1];
		end
	end

	for (genvar k = 0; k < NPROD; k++) begin : g_prod
		logic signed [COEF_W-1:0] coef;
		logic signed [LVL_W-1:0]  opnd;
		assign coef = coefficients[COEF_W*k +: COEF_W];
		if (k == 0) begin : g_head
			assign opnd = lvl;
		end else begin : g_line
			assign opnd = line_q[k-1];
		end
		assign prod_d[k] = (TW'(k) < taps) ? PROD_W'(coef * opnd) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
			tail_q  <= '0;
			vld_s1  <= 1'b0;
			out_vld_q <= 1'b0;
			for (int i = 0; i < LINE_DEPTH; i++) begin
				line_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == BK_RUN && state_d == BK_TAIL) begin
				tail_q <= TW'(1);
			end else if (state_q == BK_TAIL && emit) begin
				tail_q <= tail_q + TW'(1);
			end
			if (emit) begin
				line_q <= line_d;
			end
			if (s1_can) begin
				vld_s1 <= emit;
			end
			if (out_load) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_can && emit) begin
			prod_s1 <= prod_d;
			last_s1 <= last;
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < NPROD; k++) begin
			sum = sum + SUM_W'(prod_s1[k]);
		end
	end

	// Saturate only the single positive overflow; narrow output wraps.
	always_ff @(posedge clk) begin
		if (out_load && vld_s1) begin
			full_q   <= (!sum[SUM_W-1] && sum[FULL_W-1]) ?
				{1'b0, {(FULL_W-1){1'b1}}} : sum[FULL_W-1:0];
			narrow_q <= sum[NARROW_LSB +: NARROW_W];
			final_q  <= last_s1;
		end
	end

	assign results.valid      = out_vld_q;
	assign results.full_sum   = full_q;
	assign results.narrow_out = narrow_q;
	assign results.final_out  = final_q;

	assign stat.tail = (state_q == BK_TAIL);
	assign stat.emit = emit;
	assign stat.last = last;

endmodule

`default_nettype wire

@@ tb/sv/qfir_output_checker.sv @@
// Output checker for the quantized FIR filter: register shadow, output prediction, compare.
`timescale 1ns / 100ps

module qfir_output_checker
	import qfir_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	qfir_in_if                samples_mon,
	qfir_out_if               results_mon,
	output int                outputs_due,
	output int                mismatch_count
);

	localparam int FULL_MAX   = (1 << (FULL_W - 1)) - 1;
	localparam int LINE_DEPTH = MAX_TAPS_DEF - 1;
	localparam int QUANT_THR  = (LEVELS_DEF - 1 < STORED_THR) ? LEVELS_DEF - 1 : STORED_THR;

	typedef struct packed {
		logic signed [FULL_W-1:0]   full_sum;
		logic signed [NARROW_W-1:0] narrow_out;
		logic                       final_out;
	} filter_output_t;

	logic [REG_W-1:0]        coef_bank;
	logic [TAP_CNT_W-1:0]    tap_setting;
	logic [THR_LO_W-1:0]     thr_lo_bank;
	logic [THR_HI_W-1:0]     thr_hi_bank;
	logic [REG_W-1:0]        level_book;
	logic signed [LVL_W-1:0] level_history [LINE_DEPTH];
	filter_output_t          outputs_expected [$];
	int                      outputs_seen;

	initial begin
		mismatch_count = 0;
		outputs_due    = 0;
		outputs_seen   = 0;
	end

	function automatic int taps_in_effect();
		if (tap_setting == 0)
			return 1;
		if (tap_setting > MAX_TAPS_DEF)
			return MAX_TAPS_DEF;
		return int'(tap_setting);
	endfunction

	// Level index is the count of thresholds strictly below the sample.
	function automatic logic signed [LVL_W-1:0] quantize_sample(
		input logic signed [SAMPLE_WIDTH_DEF-1:0] s);
		int                      idx;
		logic signed [THR_W-1:0] thr;
		idx = 0;
		for (int i = 0; i < QUANT_THR; i++) begin
			thr = (i < 4) ? thr_lo_bank[THR_W*i +: THR_W] : thr_hi_bank[THR_W*(i-4) +: THR_W];
			if (int'(thr) < int'(s))
				idx++;
		end
		if (idx >= CB_LEVELS)
			return '0;
		return level_book[LVL_W*idx +: LVL_W];
	endfunction

	function automatic void push_output(input logic signed [LVL_W-1:0] level, input int taps,
		input logic last);
		int             acc;
		filter_output_t out;
		acc = int'($signed(coef_bank[COEF_W-1:0])) * int'(level);
		for (int k = 1; k < taps && k < COEF_SLOTS; k++)
			acc += int'($signed(coef_bank[COEF_W*k +: COEF_W])) * int'(level_history[k-1]);
		for (int i = LINE_DEPTH - 1; i > 0; i--)
			level_history[i] = level_history[i-1];
		level_history[0] = level;
		if (acc > FULL_MAX)
			out.full_sum = FULL_W'(FULL_MAX);
		else
			out.full_sum = acc[FULL_W-1:0];
		out.narrow_out = acc[NARROW_LSB +: NARROW_W];
		out.final_out  = last;
		outputs_expected = {outputs_expected, out};
	endfunction

	// One sample gives one output; a block end adds the tail and clears the line.
	function automatic void predict_sample(input logic signed [SAMPLE_WIDTH_DEF-1:0] s,
		input logic blk_end);
		int taps;
		taps = taps_in_effect();
		push_output(quantize_sample(s), taps, blk_end && taps == 1);
		if (blk_end) begin
			for (int t = 1; t < taps; t++)
				push_output('0, taps, t == taps - 1);
			foreach (level_history[i])
				level_history[i] = '0;
		end
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] qfir output %0d: %s", $time, outputs_seen, what);
		mismatch_count++;
	endtask

	task automatic check_output();
		filter_output_t want;
		outputs_seen++;
		if (outputs_expected.size() == 0) begin
			report_mismatch($sformatf("unexpected output, full_sum %0d", results_mon.full_sum));
			return;
		end
		want = outputs_expected.pop_front();
		if (results_mon.full_sum !== want.full_sum)
			report_mismatch($sformatf("full_sum %0d, expected %0d",
				results_mon.full_sum, want.full_sum));
		if (results_mon.narrow_out !== want.narrow_out)
			report_mismatch($sformatf("narrow_out %0d, expected %0d",
				results_mon.narrow_out, want.narrow_out));
		if (results_mon.final_out !== want.final_out)
			report_mismatch($sformatf("final_out %b, expected %b",
				results_mon.final_out, want.final_out));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_bank   = '0;
			tap_setting = TAP_COUNT_RESET;
			thr_lo_bank = '0;
			thr_hi_bank = '0;
			level_book  = '0;
			foreach (level_history[i])
				level_history[i] = '0;
			outputs_expected.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:REG_IDX_LSB])
					REG_COEF:     coef_bank   = pwdata[REG_W-1:0];
					REG_TAPS:     tap_setting = pwdata[TAP_CNT_W-1:0];
					REG_THR_LO:   thr_lo_bank = pwdata[THR_LO_W-1:0];
					REG_THR_HI:   thr_hi_bank = pwdata[THR_HI_W-1:0];
					REG_CODEBOOK: level_book  = pwdata[REG_W-1:0];
					default: ;
				endcase
			end
			if (samples_mon.valid && samples_mon.ready)
				predict_sample(samples_mon.sample, samples_mon.block_end);
			if (results_mon.valid && results_mon.ready)
				check_output();
		end
		outputs_due = outputs_expected.size();
	end

endmodule

@@ tb/sv/testbench.sv @@
// Testbench top for the quantized FIR filter: clock, reset, stimulus, output drain and verdict.
`timescale 1ns / 100ps

module testbench;
	import qfir_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 4;
	localparam int MAX_GAP         = 11;
	localparam int LONG_HOLD       = 90;
	localparam int SETTLE_CYCLES   = 8;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int MAX_BLOCK_LEN   = 10;
	localparam int RUN_LIMIT_NS    = 3_000_000;

	// Register index outside the map; a write there must change nothing.
	localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(5);

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int                outputs_due;
	int                mismatch_count;
	int                outputs_taken;
	bit                sender_idles;

	// Threshold copy kept here only to aim samples at the partition edges.
	logic [THR_LO_W-1:0] thr_lo_cfg;
	logic [THR_HI_W-1:0] thr_hi_cfg;

	qfir_in_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)) in_ch ();
	qfir_out_if                                  out_ch ();

	quantized_fir_filter_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (in_ch),
		.results (out_ch)
	);

	qfir_output_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.samples_mon    (in_ch),
		.results_mon    (out_ch),
		.outputs_due    (outputs_due),
		.mismatch_count (mismatch_count)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Hard stop in case the block hangs or loses outputs.
	initial begin
		#(RUN_LIMIT_NS);
		$display("** quantized_fir_filter_top: FAILED **");
		$finish;
	end

	// Register write: setup cycle, then access cycle until pready. Leave the bus
	// idle after each write so psel never drops and rises in one step.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx) << REG_IDX_LSB;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Write the full register set; only called while the filter is idle.
	task automatic load_setting(input logic [DATA_W-1:0] coef, input logic [DATA_W-1:0] taps,
		input logic [DATA_W-1:0] thr_lo, input logic [DATA_W-1:0] thr_hi,
		input logic [DATA_W-1:0] book);
		write_reg(REG_COEF, coef);
		write_reg(REG_TAPS, taps);
		write_reg(REG_THR_LO, thr_lo);
		write_reg(REG_THR_HI, thr_hi);
		write_reg(REG_CODEBOOK, book);
		thr_lo_cfg = thr_lo[THR_LO_W-1:0];
		thr_hi_cfg = thr_hi[THR_HI_W-1:0];
	endtask

	// Offer one sample and hold it until the transfer. Enter and leave at a
	// falling edge; valid stays high when the next gap is zero.
	task automatic send_sample(input logic signed [SAMPLE_WIDTH_DEF-1:0] s, input logic blk_end);
		int gap;
		gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample    <= s;
		in_ch.block_end <= blk_end;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// A third of the samples on or next to a threshold, a sixth at the extremes, the rest uniform.
	function automatic logic signed [SAMPLE_WIDTH_DEF-1:0] pick_sample();
		int                      i;
		int                      delta;
		logic signed [THR_W-1:0] thr;
		i     = $urandom_range(0, STORED_THR - 1);
		thr   = (i < 4) ? thr_lo_cfg[THR_W*i +: THR_W] : thr_hi_cfg[THR_W*(i-4) +: THR_W];
		delta = int'($urandom_range(0, 2)) - 1;
		case ($urandom_range(0, 5))
			0:       return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
			1, 2:    return SAMPLE_WIDTH_DEF'(int'(thr) + delta);
			default: return SAMPLE_WIDTH_DEF'($urandom);
		endcase
	endfunction

	// A block is a run of samples closed by block_end.
	task automatic send_block(input int len);
		for (int j = 0; j < len; j++)
			send_sample(pick_sample(), j == len - 1);
	endtask

	// Drop valid, wait until every predicted output has gone out, then let
	// the pipeline settle before the next register write.
	task automatic wait_all_outputs();
		in_ch.valid <= 1'b0;
		while (outputs_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Random setting per phase: tap count cycles through one tap, eight taps
	// and random codes (out-of-range ones included); thresholds alternate
	// between sorted and arbitrary order. Upper bits of the narrow registers
	// are random so the masking gets exercised.
	task automatic load_random_setting(input int phase);
		logic [TAP_CNT_W-1:0] taps;
		logic [THR_LO_W-1:0]  lo;
		logic [THR_HI_W-1:0]  hi;
		int                   thr_q [$];
		case (phase % 4)
			0:       taps = TAP_CNT_W'(1);
			1:       taps = TAP_CNT_W'(MAX_TAPS_DEF);
			default: taps = TAP_CNT_W'($urandom_range(0, 15));
		endcase
		if (phase % 2 == 0) begin
			repeat (STORED_THR)
				thr_q = {thr_q, int'($urandom_range(0, 65535)) - 32768};
			thr_q.sort();
			lo = {16'(thr_q[3]), 16'(thr_q[2]), 16'(thr_q[1]), 16'(thr_q[0])};
			hi = {16'(thr_q[6]), 16'(thr_q[5]), 16'(thr_q[4])};
		end else begin
			lo = {$urandom, $urandom};
			hi = {16'($urandom), $urandom};
		end
		load_setting({$urandom, $urandom}, {$urandom, 28'($urandom), taps}, lo,
			{16'($urandom), hi}, {$urandom, $urandom});
	endtask

	// Result side: random stalls per output, with calm stretches, and two
	// long hold-offs so the queue fills and samples.ready drops while the
	// sender keeps offering.
	initial begin : result_drain
		int stall;
		out_ch.ready  = 1'b0;
		outputs_taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (outputs_taken == 200 || outputs_taken == 700) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			stall = ((outputs_taken / 64) % 3 != 2) ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			outputs_taken++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int sent;
		int len;

		// Drive every input known from time zero, then hold reset low before releasing it at a falling edge.
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		in_ch.valid     = 1'b0;
		in_ch.sample    = '0;
		in_ch.block_end = 1'b0;
		sender_idles    = 1'b1;
		thr_lo_cfg      = '0;
		thr_hi_cfg      = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset setting: eight taps, zero codebook; a block end flushes seven tail outputs.
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b1);
		wait_all_outputs();

		// All coefficients and level 0 at the most negative code: eight equal
		// samples drive the sum to its single overflowing value. Thresholds
		// ascend -1.5 .. 1.5 in steps of 0.5. The write to the spare index
		// comes after the real setting and must leave it untouched.
		load_setting({COEF_SLOTS{8'h80}}, DATA_W'(MAX_TAPS_DEF),
			{16'h0000, 16'hFF80, 16'hFF00, 16'hFE80},
			{16'h0000, 16'h0180, 16'h0100, 16'h0080},
			{8'h7F, 8'h30, 8'h10, 8'h01, 8'hFF, 8'hF0, 8'hC0, 8'h80});
		write_reg(REG_SPARE, '1);
		repeat (MAX_TAPS_DEF) send_sample(16'sh8000, 1'b0);
		send_sample(16'shFE80, 1'b0);   // equal to the lowest threshold: level 0
		send_sample(16'shFE81, 1'b0);   // just above it: level 1
		send_sample(16'sh0000, 1'b0);   // equal to the middle threshold
		send_sample(16'sh0001, 1'b0);
		send_sample(16'sh7FFF, 1'b1);   // above all thresholds: top level
		wait_all_outputs();

		// One tap, largest positive coefficient, thresholds in no order:
		// a block end gives a single output that carries the final flag.
		load_setting({$urandom, 24'($urandom), 8'h7F}, DATA_W'(1), {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, 24'($urandom), 8'h7F});
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(SAMPLE_WIDTH_DEF'($urandom), 1'b1);
		wait_all_outputs();

		// Tap count zero acts as one tap.
		write_reg(REG_TAPS, '0);
		send_sample(SAMPLE_WIDTH_DEF'($urandom), 1'b0);
		send_sample(SAMPLE_WIDTH_DEF'($urandom), 1'b1);
		wait_all_outputs();

		// Tap count above the maximum acts as the maximum.
		write_reg(REG_TAPS, DATA_W'(4'hF));
		send_block(3);
		wait_all_outputs();

		// Random part: blocks of random length under a new setting per phase.
		// Every third phase the sender never idles.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			load_random_setting(phase);
			sender_idles = (phase % 3) != 2;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				len = $urandom_range(1, MAX_BLOCK_LEN);
				send_block(len);
				sent += len;
			end
			wait_all_outputs();
		end

		if (mismatch_count == 0)
			$display("** quantized_fir_filter_top: PASSED **");
		else
			$display("** quantized_fir_filter_top: FAILED **");
		$finish;
	end

endmodule
